// ===== src/numa_buddy_page_allocator_defines.svh =====
// Assertion macros for the buddy page allocator.
`ifndef NUMA_BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define NUMA_BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define NBPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define NBPA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define NBPA_ASSERT(label, clk, rst_n, prop, msg)
`define NBPA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== src/nbpa_pkg.sv =====
// Shared constants and codes of the buddy page allocator.
package nbpa_pkg;
    localparam int NODES_DEF = 4;
    localparam int ORDERS_DEF = 8;
    localparam int PAGES_DEF = 1024;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE = 1'b1;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_FALLBACK = 1'b1;
endpackage

// ===== src/numa_buddy_page_allocator.sv =====
// Per-node buddy page allocator built around a page memory and a list memory.
//
//  channel   signals                                          handshake
//  request   i_kind i_node i_block_order i_page_index         start, busy
//  result    o_status o_granted_node o_granted_page
//            o_node_free_pages                                 o_done (one cycle)
//  config    i_cfg_idx i_cfg_wdata                             i_cfg_we
//
// An allocate that hits its own order unlinks the head block and strobes its result. Each
// empty larger order, each fallback entry tried (or skipped) and each split half lengthens
// the request; each list step is a read-modify-write of the list memory and the page
// memory. A free scans up to ORDERS + 2^order page entries at one a cycle, closes the
// scan, merges with each free buddy, then pushes the block and reports. A bad request
// goes from the check straight to its result. After reset a clearing pass over all
// NODES * PAGES_PER_NODE page entries (4096 by default) runs with busy high. The result
// word is shown for one cycle; the receiver cannot stall.
`include "numa_buddy_page_allocator_defines.svh"
module numa_buddy_page_allocator #(
    parameter int NODES = nbpa_pkg::NODES_DEF,
    parameter int ORDERS = nbpa_pkg::ORDERS_DEF,
    parameter int PAGES_PER_NODE = nbpa_pkg::PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [1:0]  i_node,
    input  logic [2:0]  i_block_order,
    input  logic [9:0]  i_page_index,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [1:0]  o_granted_node,
    output logic [9:0]  o_granted_page,
    output logic [10:0] o_node_free_pages,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    import nbpa_pkg::*;

    localparam int PW = $clog2(PAGES_PER_NODE);
    localparam int LW = $clog2(PAGES_PER_NODE + 1);
    localparam int OBW = (ORDERS > 1) ? $clog2(ORDERS) : 1;
    localparam int OW = $clog2(ORDERS + 1);
    localparam int PDEPTH = NODES * PAGES_PER_NODE;
    localparam int MAW = $clog2(PDEPTH);
    localparam int LDEPTH = NODES * ORDERS;
    localparam int LAW = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SCW = $clog2(ORDERS + PAGES_PER_NODE + 1);
    localparam int AW = (PW > ORDERS) ? PW : ORDERS;
    localparam int SW = (LW + 1 > 11) ? LW + 1 : 11;
    localparam logic [LW-1:0] NIL = LW'(PAGES_PER_NODE);

    localparam logic [4:0] S_CLR = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_CHK = 5'd2;
    localparam logic [4:0] S_A_RD = 5'd3;
    localparam logic [4:0] S_A_CHK = 5'd4;
    localparam logic [4:0] S_FB = 5'd5;
    localparam logic [4:0] S_A_GOT = 5'd6;
    localparam logic [4:0] S_A_FIN = 5'd7;
    localparam logic [4:0] S_UL0 = 5'd8;
    localparam logic [4:0] S_UL1 = 5'd9;
    localparam logic [4:0] S_UL2 = 5'd10;
    localparam logic [4:0] S_UL3 = 5'd11;
    localparam logic [4:0] S_PS0 = 5'd12;
    localparam logic [4:0] S_PS1 = 5'd13;
    localparam logic [4:0] S_PS2 = 5'd14;
    localparam logic [4:0] S_SCAN = 5'd15;
    localparam logic [4:0] S_MG0 = 5'd16;
    localparam logic [4:0] S_MG1 = 5'd17;
    localparam logic [4:0] S_MG2 = 5'd18;
    localparam logic [4:0] S_F_FIN = 5'd19;
    localparam logic [4:0] S_OUT = 5'd20;

    typedef struct packed {
        logic           free;
        logic [OBW-1:0] order;
        logic [LW-1:0]  next;
        logic [LW-1:0]  prev;
    } t_page_ent;

    typedef struct packed {
        logic [LW-1:0] head;
        logic [LW-1:0] len;
    } t_list_ent;

    function automatic logic [MAW-1:0] pidx(input logic [1:0] n, input logic [PW-1:0] p);
        pidx = MAW'(MAW'(n) * MAW'(PAGES_PER_NODE)) + MAW'(p);
    endfunction

    function automatic logic [LAW-1:0] lidx(input logic [1:0] n, input logic [OW-1:0] o);
        lidx = LAW'(LAW'(n) * LAW'(ORDERS)) + LAW'(o);
    endfunction

    t_page_ent m_page [PDEPTH];
    t_list_ent m_list [LDEPTH];

    logic [4:0]      r_state, n_state, r_ret, n_ret;
    logic [MAW-1:0]  r_clr, n_clr;
    logic            r_kind, n_kind;
    logic [1:0]      r_node, n_node, r_cnode, n_cnode, r_src, n_src;
    logic [2:0]      r_ord, n_ord;
    logic [9:0]      r_pg, n_pg;
    logic [OW-1:0]   r_cord, n_cord, r_j, n_j;
    logic [PW-1:0]   r_p, n_p, r_q, n_q, r_cur, n_cur, r_gp, n_gp;
    logic [2:0]      r_fb, n_fb;
    logic            r_infb, n_infb;
    logic [LW-1:0]   r_nx, n_nx, r_pv, n_pv, r_head, n_head;
    logic [SCW-1:0]  r_sc_cnt, n_sc_cnt, r_sc_k, n_sc_k;
    logic            r_sc_pend, n_sc_pend;
    logic [1:0]      r_st, n_st, r_gn, n_gn;
    logic            r_done, n_done;
    logic [1:0]      r_o_status, n_o_status, r_o_gn, n_o_gn;
    logic [9:0]      r_o_gp, n_o_gp;
    logic [10:0]     r_o_free, n_o_free;
    logic [2:0]      r_ncount;
    logic [31:0]     r_fbt;
    logic [LW-1:0]   r_ft [NODES];

    t_page_ent       r_pm_rd, pw_data;
    t_list_ent       r_lm_rd, lw_data;
    logic [MAW-1:0]  pr_addr, pw_addr;
    logic [LAW-1:0]  lr_addr, lw_addr;
    logic            pw_en_free, pw_en_ord, pw_en_next, pw_en_prev;
    logic            lw_en_head, lw_en_len;
    logic            ft_we;
    logic [NW-1:0]   ft_idx;
    logic [LW-1:0]   ft_wdata;

    logic            node_ok, ord_ok, fnode_ok;
    logic [1:0]      fnode;
    logic [9:0]      fsize10;
    logic [LW-1:0]   size_lw;
    logic [AW-1:0]   buddy;
    logic [SCW-1:0]  sc_total;
    logic [PW-1:0]   sc_page;
    logic            sc_hit;

    always_comb begin
        node_ok = (32'(r_node) < 32'(r_ncount)) && (32'(r_node) < NODES);
        ord_ok = 32'(r_ord) < ORDERS;
        fnode = r_fbt[{r_node, r_fb[1:0], 1'b0} +: 2];
        fnode_ok = (32'(fnode) < 32'(r_ncount)) && (32'(fnode) < NODES);
        fsize10 = 10'(1) << r_ord;
        size_lw = LW'(1) << r_ord;
        buddy = AW'(r_cur) ^ (AW'(1) << r_cord);
        sc_total = SCW'(ORDERS) + SCW'(size_lw);
        if (32'(r_sc_cnt) < ORDERS) begin
            sc_page = PW'(r_pg) & ~((PW'(1) << r_sc_cnt) - PW'(1));
        end else begin
            sc_page = PW'(r_pg) + PW'(r_sc_cnt - SCW'(ORDERS));
        end
        if (32'(r_sc_k) < ORDERS) begin
            sc_hit = r_pm_rd.free && (32'(r_pm_rd.order) >= 32'(r_sc_k));
        end else begin
            sc_hit = r_pm_rd.free;
        end
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_clr = r_clr;
        n_kind = r_kind; n_node = r_node; n_ord = r_ord; n_pg = r_pg;
        n_cnode = r_cnode; n_src = r_src; n_cord = r_cord; n_j = r_j;
        n_p = r_p; n_q = r_q; n_cur = r_cur; n_gp = r_gp;
        n_fb = r_fb; n_infb = r_infb;
        n_nx = r_nx; n_pv = r_pv; n_head = r_head;
        n_sc_cnt = r_sc_cnt; n_sc_k = r_sc_k; n_sc_pend = r_sc_pend;
        n_st = r_st; n_gn = r_gn;
        n_done = 1'b0;
        n_o_status = r_o_status; n_o_gn = r_o_gn; n_o_gp = r_o_gp; n_o_free = r_o_free;
        pr_addr = '0; pw_addr = '0; pw_data = '0;
        pw_en_free = 1'b0; pw_en_ord = 1'b0; pw_en_next = 1'b0; pw_en_prev = 1'b0;
        lr_addr = '0; lw_addr = '0; lw_data = '0;
        lw_en_head = 1'b0; lw_en_len = 1'b0;
        ft_we = 1'b0; ft_idx = '0; ft_wdata = '0;

        case (r_state)
            S_CLR: begin
                pw_addr = r_clr;
                pw_en_free = 1'b1;
                if ({1'b0, r_clr} < (MAW + 1)'(LDEPTH)) begin
                    lw_addr = LAW'(r_clr);
                    lw_en_head = 1'b1;
                    lw_en_len = 1'b1;
                    lw_data.head = NIL;
                end
                if (r_clr == MAW'(PDEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + MAW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_kind = i_kind;
                    n_node = i_node;
                    n_ord = i_block_order;
                    n_pg = i_page_index;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_st = ST_BAD;
                n_gn = 2'd0;
                n_gp = '0;
                n_cnode = r_node;
                n_src = r_node;
                n_cord = OW'(r_ord);
                n_infb = 1'b0;
                n_fb = 3'd1;
                n_sc_cnt = '0;
                n_sc_pend = 1'b0;
                n_cur = PW'(r_pg);
                if (!node_ok || !ord_ok) begin
                    n_state = S_OUT;
                end else if (r_kind == KIND_ALLOC) begin
                    n_state = S_A_RD;
                end else if ((r_pg & (fsize10 - 10'd1)) == 10'd0 &&
                             SW'(r_pg) + SW'(fsize10) <= SW'(PAGES_PER_NODE)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_A_RD: begin
                lr_addr = lidx(r_cnode, r_cord);
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (r_lm_rd.len != '0 && r_lm_rd.head < NIL) begin
                    n_p = PW'(r_lm_rd.head);
                    n_j = r_cord;
                    n_src = r_cnode;
                    n_ret = S_A_GOT;
                    n_state = S_UL0;
                end else if (!r_infb && 32'(r_cord) + 1 < ORDERS) begin
                    n_cord = r_cord + OW'(1);
                    n_state = S_A_RD;
                end else begin
                    n_infb = 1'b1;
                    n_cord = OW'(r_ord);
                    n_state = S_FB;
                end
            end
            S_FB: begin
                if (r_fb < 3'd4 && r_fb < r_ncount) begin
                    n_fb = r_fb + 3'd1;
                    if (fnode_ok) begin
                        n_cnode = fnode;
                        n_state = S_A_RD;
                    end
                end else begin
                    n_st = ST_NOMEM;
                    n_state = S_OUT;
                end
            end
            S_A_GOT: begin
                // Split: each upper half goes on the list one order down.
                if (r_j > OW'(r_ord)) begin
                    n_j = r_j - OW'(1);
                    n_cord = r_j - OW'(1);
                    n_q = r_p + (PW'(1) << (r_j - OW'(1)));
                    n_ret = S_A_GOT;
                    n_state = S_PS0;
                end else begin
                    n_state = S_A_FIN;
                end
            end
            S_A_FIN: begin
                ft_we = 1'b1;
                ft_idx = NW'(r_src);
                ft_wdata = (r_ft[NW'(r_src)] >= size_lw) ? r_ft[NW'(r_src)] - size_lw : '0;
                n_st = ST_OK;
                n_gn = r_src;
                n_gp = r_p;
                n_state = S_OUT;
            end
            S_UL0: begin
                pr_addr = pidx(r_cnode, r_p);
                lr_addr = lidx(r_cnode, r_cord);
                n_state = S_UL1;
            end
            S_UL1: begin
                n_nx = r_pm_rd.next;
                n_pv = r_pm_rd.prev;
                lw_addr = lidx(r_cnode, r_cord);
                lw_en_len = 1'b1;
                lw_data.len = (r_lm_rd.len != '0) ? r_lm_rd.len - LW'(1) : '0;
                if (r_pm_rd.prev < NIL) begin
                    pw_addr = pidx(r_cnode, PW'(r_pm_rd.prev));
                    pw_en_next = 1'b1;
                    pw_data.next = r_pm_rd.next;
                end else begin
                    lw_en_head = 1'b1;
                    lw_data.head = r_pm_rd.next;
                end
                n_state = S_UL2;
            end
            S_UL2: begin
                if (r_nx < NIL) begin
                    pw_addr = pidx(r_cnode, PW'(r_nx));
                    pw_en_prev = 1'b1;
                    pw_data.prev = r_pv;
                end
                n_state = S_UL3;
            end
            S_UL3: begin
                pw_addr = pidx(r_cnode, r_p);
                pw_en_free = 1'b1;
                n_state = r_ret;
            end
            S_PS0: begin
                lr_addr = lidx(r_cnode, r_cord);
                n_state = S_PS1;
            end
            S_PS1: begin
                pw_addr = pidx(r_cnode, r_q);
                pw_en_free = 1'b1;
                pw_en_ord = 1'b1;
                pw_en_next = 1'b1;
                pw_en_prev = 1'b1;
                pw_data.free = 1'b1;
                pw_data.order = OBW'(r_cord);
                pw_data.next = r_lm_rd.head;
                pw_data.prev = NIL;
                lw_addr = lidx(r_cnode, r_cord);
                lw_en_head = 1'b1;
                lw_en_len = 1'b1;
                lw_data.head = LW'(r_q);
                lw_data.len = r_lm_rd.len + LW'(1);
                n_head = r_lm_rd.head;
                n_state = S_PS2;
            end
            S_PS2: begin
                if (r_head < NIL) begin
                    pw_addr = pidx(r_cnode, PW'(r_head));
                    pw_en_prev = 1'b1;
                    pw_data.prev = LW'(r_q);
                end
                n_state = r_ret;
            end
            S_SCAN: begin
                // One page word is read per cycle and checked the cycle after.
                if (r_sc_cnt < sc_total) begin
                    pr_addr = pidx(r_node, sc_page);
                    n_sc_k = r_sc_cnt;
                    n_sc_pend = 1'b1;
                    n_sc_cnt = r_sc_cnt + SCW'(1);
                end else begin
                    n_sc_pend = 1'b0;
                end
                if (r_sc_pend && sc_hit) begin
                    n_state = S_OUT;
                end else if (r_sc_cnt == sc_total) begin
                    n_state = S_MG0;
                end
            end
            S_MG0: begin
                if (32'(r_cord) + 1 >= ORDERS || 32'(buddy) >= PAGES_PER_NODE) begin
                    n_q = r_cur;
                    n_ret = S_F_FIN;
                    n_state = S_PS0;
                end else begin
                    pr_addr = pidx(r_cnode, PW'(buddy));
                    n_p = PW'(buddy);
                    n_state = S_MG1;
                end
            end
            S_MG1: begin
                if (r_pm_rd.free && r_pm_rd.order == OBW'(r_cord)) begin
                    n_ret = S_MG2;
                    n_state = S_UL0;
                end else begin
                    n_q = r_cur;
                    n_ret = S_F_FIN;
                    n_state = S_PS0;
                end
            end
            S_MG2: begin
                if (r_p < r_cur) begin
                    n_cur = r_p;
                end
                n_cord = r_cord + OW'(1);
                n_state = S_MG0;
            end
            S_F_FIN: begin
                ft_we = 1'b1;
                ft_idx = NW'(r_node);
                ft_wdata = r_ft[NW'(r_node)] + size_lw;
                n_st = ST_OK;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_done = 1'b1;
                n_o_status = r_st;
                n_o_gn = r_gn;
                n_o_gp = 10'(r_gp);
                n_o_free = (32'(r_node) < NODES) ? 11'(r_ft[NW'(r_node)]) : 11'd0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pm_rd <= m_page[pr_addr];
        if (pw_en_free) begin
            m_page[pw_addr].free <= pw_data.free;
        end
        if (pw_en_ord) begin
            m_page[pw_addr].order <= pw_data.order;
        end
        if (pw_en_next) begin
            m_page[pw_addr].next <= pw_data.next;
        end
        if (pw_en_prev) begin
            m_page[pw_addr].prev <= pw_data.prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lm_rd <= m_list[lr_addr];
        if (lw_en_head) begin
            m_list[lw_addr].head <= lw_data.head;
        end
        if (lw_en_len) begin
            m_list[lw_addr].len <= lw_data.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_done <= 1'b0;
            r_sc_pend <= 1'b0;
            r_ncount <= 3'd1;
            r_fbt <= '0;
            for (int i = 0; i < NODES; i++) begin
                r_ft[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_done <= n_done;
            r_sc_pend <= n_sc_pend;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_NODE_COUNT) begin
                    r_ncount <= i_cfg_wdata[2:0];
                end else begin
                    r_fbt <= i_cfg_wdata;
                end
            end
            if (ft_we) begin
                r_ft[ft_idx] <= ft_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_kind <= n_kind;
        r_node <= n_node;
        r_ord <= n_ord;
        r_pg <= n_pg;
        r_cnode <= n_cnode;
        r_src <= n_src;
        r_cord <= n_cord;
        r_j <= n_j;
        r_p <= n_p;
        r_q <= n_q;
        r_cur <= n_cur;
        r_gp <= n_gp;
        r_fb <= n_fb;
        r_infb <= n_infb;
        r_nx <= n_nx;
        r_pv <= n_pv;
        r_head <= n_head;
        r_sc_cnt <= n_sc_cnt;
        r_sc_k <= n_sc_k;
        r_st <= n_st;
        r_gn <= n_gn;
        r_o_status <= n_o_status;
        r_o_gn <= n_o_gn;
        r_o_gp <= n_o_gp;
        r_o_free <= n_o_free;
    end

    assign busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_status = r_o_status;
    assign o_granted_node = r_o_gn;
    assign o_granted_page = r_o_gp;
    assign o_node_free_pages = r_o_free;

    `NBPA_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted word did not raise busy")
    `NBPA_ASSERT(a_status_code, i_clk, i_rst_n, o_done |-> (o_status == ST_OK || o_status == ST_NOMEM || o_status == ST_BAD), "status code out of range")
    `NBPA_ASSERT(a_fail_no_grant, i_clk, i_rst_n, (o_done && o_status != ST_OK) |-> (o_granted_node == 2'd0 && o_granted_page == 10'd0), "failed word carries a grant")
    `NBPA_ASSERT_NR(a_reset_clear, i_clk, !i_rst_n |=> (!o_done && busy), "reset did not start the clearing pass")
endmodule
